// File: src/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// File: src/cba_pkg.sv
package cba_pkg;

   localparam int NUM_BUFFERS  = 256;
   localparam int BUFFER_BYTES = 16;

   localparam int IDX_W      = $clog2(NUM_BUFFERS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int BYTES_W    = 13;
   localparam int NEED_W     = BYTES_W + 1;
   localparam int FIDX_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int START_W    = 8;
   localparam int REQ_DATA_W = ((BYTES_W + FIDX_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((STATUS_W + START_W + 7) / 8) * 8;

   typedef logic [IDX_W-1:0]       idx_type;
   typedef logic [CNT_W-1:0]       cnt_type;
   typedef logic [NEED_W-1:0]      need_type;
   typedef logic [NUM_BUFFERS-1:0] map_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_ALLOC_FAIL = 2'd1,
      STATUS_FREE_NONE  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_MARK,
      ST_WALK,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;
      logic       scan;
      logic       mark;
      logic       walk;
      logic       set_status;
      status_type status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic op_free;
      logic need_bad;
      logic free_bad;
      logic scan_end;
      logic hit;
      logic cur_alloc;
      logic cur_cont;
      logic mark_last;
   } sts_type;

endpackage

// File: src/cba_ctrl.sv
module cba_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             out_free,
   output logic             emit,
   output cba_pkg::cmd_type cmd,
   input  cba_pkg::sts_type sts
);

   cba_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cba_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      emit           = 1'b0;
      cmd            = '0;
      cmd.status     = cba_pkg::STATUS_OK;
      case (state_ff)
         cba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = cba_pkg::ST_CHECK;
            end
         end
         cba_pkg::ST_CHECK: begin
            if (sts.op_free) begin
               if (sts.free_bad) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = cba_pkg::STATUS_FREE_NONE;
                  state_in       = cba_pkg::ST_DONE;
               end else begin
                  state_in = cba_pkg::ST_WALK;
               end
            end else if (sts.need_bad) begin
               cmd.set_status = 1'b1;
               cmd.status     = cba_pkg::STATUS_ALLOC_FAIL;
               state_in       = cba_pkg::ST_DONE;
            end else begin
               state_in = cba_pkg::ST_SCAN;
            end
         end
         cba_pkg::ST_SCAN: begin
            if (sts.scan_end) begin
               cmd.set_status = 1'b1;
               cmd.status     = cba_pkg::STATUS_ALLOC_FAIL;
               state_in       = cba_pkg::ST_DONE;
            end else begin
               cmd.scan = 1'b1;
               if (sts.hit) begin
                  state_in = cba_pkg::ST_MARK;
               end
            end
         end
         cba_pkg::ST_MARK: begin
            cmd.mark = 1'b1;
            if (sts.mark_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = cba_pkg::STATUS_OK;
               state_in       = cba_pkg::ST_DONE;
            end
         end
         cba_pkg::ST_WALK: begin
            if (sts.scan_end || !sts.cur_alloc) begin
               cmd.set_status = 1'b1;
               state_in       = cba_pkg::ST_DONE;
            end else begin
               cmd.walk = 1'b1;
               if (!sts.cur_cont) begin
                  cmd.set_status = 1'b1;
                  state_in       = cba_pkg::ST_DONE;
               end
            end
         end
         cba_pkg::ST_DONE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = cba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cba_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: src/cba_dpath.sv
`include "assert_macros.svh"

module cba_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  cba_pkg::cmd_type              cmd,
   output cba_pkg::sts_type              sts,
   input  logic                          op_free,
   input  logic [cba_pkg::BYTES_W-1:0]   byte_count,
   input  logic [cba_pkg::FIDX_W-1:0]    free_index,
   output cba_pkg::status_type           res_status,
   output logic [cba_pkg::START_W-1:0]   res_start
);

   cba_pkg::map_type    alloc_ff, alloc_in;
   cba_pkg::map_type    cont_ff, cont_in;
   cba_pkg::cnt_type    idx_ff, run_ff;
   cba_pkg::need_type   need_ff;
   cba_pkg::idx_type    start_ff, last_ff;
   cba_pkg::status_type status_ff;
   logic                op_ff, bad_ff;

   cba_pkg::need_type need_calc;
   cba_pkg::cnt_type  first;
   logic              scan_end, cur_alloc, cur_cont, hit, mark_last;

   assign need_calc = cba_pkg::need_type'((cba_pkg::need_type'(byte_count)
                      + cba_pkg::need_type'(cba_pkg::BUFFER_BYTES - 1))
                      / cba_pkg::BUFFER_BYTES);

   assign scan_end  = (idx_ff == cba_pkg::cnt_type'(cba_pkg::NUM_BUFFERS));
   assign cur_alloc = !scan_end && alloc_ff[idx_ff[cba_pkg::IDX_W-1:0]];
   assign cur_cont  = !scan_end && cont_ff[idx_ff[cba_pkg::IDX_W-1:0]];
   assign hit       = !scan_end && !cur_alloc &&
                      (cba_pkg::need_type'(run_ff) + cba_pkg::need_type'(1) == need_ff);
   assign first     = idx_ff + cba_pkg::cnt_type'(1) - cba_pkg::cnt_type'(need_ff);
   assign mark_last = (idx_ff[cba_pkg::IDX_W-1:0] == last_ff);

   always_comb begin
      sts.op_free   = op_ff;
      sts.need_bad  = (need_ff == '0) ||
                      (need_ff > cba_pkg::need_type'(cba_pkg::NUM_BUFFERS));
      sts.free_bad  = bad_ff || !cur_alloc;
      sts.scan_end  = scan_end;
      sts.hit       = hit;
      sts.cur_alloc = cur_alloc;
      sts.cur_cont  = cur_cont;
      sts.mark_last = mark_last;
   end

   // bitmap updates: run marking and the free walk each touch the bit at idx_ff
   always_comb begin
      alloc_in = alloc_ff;
      cont_in  = cont_ff;
      if (cmd.mark) begin
         alloc_in[idx_ff[cba_pkg::IDX_W-1:0]] = 1'b1;
         cont_in[idx_ff[cba_pkg::IDX_W-1:0]]  = !mark_last;
      end else if (cmd.walk) begin
         alloc_in[idx_ff[cba_pkg::IDX_W-1:0]] = 1'b0;
         cont_in[idx_ff[cba_pkg::IDX_W-1:0]]  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff <= '0;
         cont_ff  <= '0;
      end else begin
         alloc_ff <= alloc_in;
         cont_ff  <= cont_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= op_free;
         need_ff   <= need_calc;
         bad_ff    <= (int'(free_index) >= cba_pkg::NUM_BUFFERS);
         idx_ff    <= op_free ? cba_pkg::cnt_type'(free_index) : '0;
         run_ff    <= '0;
         start_ff  <= '0;
         status_ff <= cba_pkg::STATUS_OK;
      end else begin
         if (cmd.scan) begin
            run_ff <= cur_alloc ? '0 : run_ff + cba_pkg::cnt_type'(1);
            if (hit) begin
               // go back to the head of the run to mark it
               idx_ff   <= first;
               start_ff <= first[cba_pkg::IDX_W-1:0];
               last_ff  <= idx_ff[cba_pkg::IDX_W-1:0];
            end else begin
               idx_ff <= idx_ff + cba_pkg::cnt_type'(1);
            end
         end
         if (cmd.walk || cmd.mark) begin
            idx_ff <= idx_ff + cba_pkg::cnt_type'(1);
         end
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
      end
   end

   assign res_status = status_ff;
   assign res_start  = (status_ff == cba_pkg::STATUS_OK && !op_ff) ?
                       cba_pkg::START_W'(start_ff) : '0;

   `ASSERT_IMP(a_cont_implies_alloc, clock, reset, 1'b1, (cont_ff & ~alloc_ff) == '0)
   `ASSERT_NXT(a_mark_tail, clock, reset, cmd.mark && mark_last, alloc_ff[$past(last_ff)] && !cont_ff[$past(last_ff)])
   `ASSERT_NXT(a_walk_clears, clock, reset, cmd.walk, !alloc_ff[$past(idx_ff[cba_pkg::IDX_W-1:0])])

endmodule

// File: src/contiguous_bitmap_allocator.sv
// First-fit allocator of contiguous buffer runs over a pool of NUM_BUFFERS
// buffers of BUFFER_BYTES bytes each.
// req channel: one word per request. tuser = 0 allocates a run big enough
// for byte_count bytes, tuser = 1 frees from free_index to the end of its run.
// rsp channel: exactly one word per request, in request order, carrying the
// status and, for a successful allocate, the first buffer of the run.
// A request is loaded and checked, then worked and handed off to rsp:
//   allocate: scans the buffers from buffer 0 for a free run, then goes
//             back to its head and marks each buffer of the run; a
//             failed scan ends after the last buffer;
//   free:     walks the run from free_index, clearing each buffer.
// The result word shows up on rsp in the same cycle as the next request
// can be taken. Scan, marking and free walk touch one bitmap bit per cycle;
// one request is in work at a time.
// The result sits in an output register: a new request is taken while the
// previous result waits, and if rsp_tready stays low the block holds its
// finished result and stops before its next result.
// Reset (synchronous, active high) marks every buffer free and drops any
// pending result.
module contiguous_bitmap_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic                             req_tuser,   // operation
   input  logic [cba_pkg::REQ_DATA_W-1:0]   req_tdata,   // byte_count, free_index
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [cba_pkg::RSP_DATA_W-1:0]   rsp_tdata    // status, start_index
);

   cba_pkg::cmd_type    cmd;
   cba_pkg::sts_type    sts;
   cba_pkg::status_type res_status;
   logic [cba_pkg::START_W-1:0] res_start;
   logic                emit, out_free;

   logic                        rsp_valid_ff;
   cba_pkg::status_type         rsp_status_ff;
   logic [cba_pkg::START_W-1:0] rsp_start_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   cba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .out_free  (out_free),
      .emit      (emit),
      .cmd       (cmd),
      .sts       (sts)
   );

   cba_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .op_free    (req_tuser),
      .byte_count (req_tdata[cba_pkg::BYTES_W-1:0]),
      .free_index (req_tdata[cba_pkg::BYTES_W +: cba_pkg::FIDX_W]),
      .res_status (res_status),
      .res_start  (res_start)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= res_status;
         rsp_start_ff  <= res_start;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = cba_pkg::RSP_DATA_W'({rsp_start_ff, rsp_status_ff});

endmodule

// File: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam int ITEMS_PER_PHASE = 300;
   // worst request: full scan plus marking
   localparam int SETTLE_CYCLES   = 2 * cba_pkg::NUM_BUFFERS + 40;
   localparam int CYCLE_LIMIT     = 5_000_000;

   typedef struct packed {
      cba_pkg::status_type            status;
      logic [cba_pkg::START_W-1:0]    start_index;
   } alloc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic                           req_tuser  = OP_ALLOC;   // operation
   logic [cba_pkg::REQ_DATA_W-1:0] req_tdata  = '0;         // byte_count, free_index
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [cba_pkg::RSP_DATA_W-1:0] rsp_tdata;               // status, start_index

   contiguous_bitmap_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // predicted pool state
   bit in_use   [cba_pkg::NUM_BUFFERS];
   bit chained  [cba_pkg::NUM_BUFFERS];

   alloc_result_type pending_results[$];
   int error_count   = 0;
   int alloc_ok      = 0;
   int alloc_refused = 0;
   int free_ok       = 0;
   int free_missed   = 0;

   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic int buffers_in_use();
      int total;
      total = 0;
      for (int i = 0; i < cba_pkg::NUM_BUFFERS; i++) total += in_use[i];
      return total;
   endfunction

   function automatic alloc_result_type predict_allocate(
      input logic [cba_pkg::BYTES_W-1:0] bytes);
      alloc_result_type r;
      int need;
      int run;
      int first;
      bit found;
      r.status      = cba_pkg::STATUS_ALLOC_FAIL;
      r.start_index = '0;
      need  = (int'(bytes) + cba_pkg::BUFFER_BYTES - 1) / cba_pkg::BUFFER_BYTES;
      run   = 0;
      first = 0;
      found = 1'b0;
      if (need != 0 && need <= cba_pkg::NUM_BUFFERS) begin
         for (int i = 0; i < cba_pkg::NUM_BUFFERS && !found; i++) begin
            if (in_use[i]) begin
               run = 0;
            end else begin
               run++;
               if (run == need) begin
                  found = 1'b1;
                  first = i + 1 - need;
               end
            end
         end
      end
      if (found) begin
         for (int k = 0; k < need; k++) begin
            in_use[first + k]  = 1'b1;
            chained[first + k] = (k + 1 < need);
         end
         r.status      = cba_pkg::STATUS_OK;
         r.start_index = first[cba_pkg::START_W-1:0];
      end
      return r;
   endfunction

   function automatic alloc_result_type predict_free(input logic [cba_pkg::FIDX_W-1:0] fidx);
      alloc_result_type r;
      int n;
      bit walking;
      r.status      = cba_pkg::STATUS_OK;
      r.start_index = '0;
      n = int'(fidx);
      if (n >= cba_pkg::NUM_BUFFERS || !in_use[n]) begin
         r.status = cba_pkg::STATUS_FREE_NONE;
      end else begin
         walking = 1'b1;
         while (walking && n < cba_pkg::NUM_BUFFERS) begin
            if (!in_use[n]) begin
               walking = 1'b0;
            end else begin
               in_use[n] = 1'b0;
               if (!chained[n]) begin
                  walking = 1'b0;
               end else begin
                  chained[n] = 1'b0;
                  n++;
               end
            end
         end
      end
      return r;
   endfunction

   function automatic void predict_request(input logic op,
                                           input logic [cba_pkg::BYTES_W-1:0] bytes,
                                           input logic [cba_pkg::FIDX_W-1:0] fidx);
      alloc_result_type r;
      if (op == OP_ALLOC) begin
         r = predict_allocate(bytes);
         if (r.status == cba_pkg::STATUS_OK) alloc_ok++;
         else alloc_refused++;
      end else begin
         r = predict_free(fidx);
         if (r.status == cba_pkg::STATUS_OK) free_ok++;
         else free_missed++;
      end
      pending_results.push_back(r);
   endfunction

   // first buffer of some live run, or -1 when the pool is empty
   function automatic int pick_run_start();
      int starts[$];
      for (int i = 0; i < cba_pkg::NUM_BUFFERS; i++)
         if (in_use[i] && (i == 0 || !in_use[i-1] || !chained[i-1])) starts.push_back(i);
      if (starts.size() == 0) return -1;
      return starts[$urandom_range(starts.size() - 1)];
   endfunction

   function automatic int pick_used_buffer();
      int used[$];
      for (int i = 0; i < cba_pkg::NUM_BUFFERS; i++)
         if (in_use[i]) used.push_back(i);
      if (used.size() == 0) return -1;
      return used[$urandom_range(used.size() - 1)];
   endfunction

   // valid stays high between back-to-back words; it drops only on a gap
   task automatic send_word(input logic op, input logic [cba_pkg::BYTES_W-1:0] bytes,
                            input logic [cba_pkg::FIDX_W-1:0] fidx);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= cba_pkg::REQ_DATA_W'({fidx, bytes});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(op, bytes, fidx);
   endtask

   task automatic send_alloc(input int bytes);
      send_word(OP_ALLOC, bytes[cba_pkg::BYTES_W-1:0], cba_pkg::FIDX_W'($urandom));
   endtask

   task automatic send_free(input int fidx);
      send_word(OP_FREE, cba_pkg::BYTES_W'($urandom), fidx[cba_pkg::FIDX_W-1:0]);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result word with no request outstanding: tdata=%h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[cba_pkg::STATUS_W-1:0] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status,
                      rsp_tdata[cba_pkg::STATUS_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[cba_pkg::STATUS_W +: cba_pkg::START_W] !== want.start_index) begin
               $error("start_index: expected %0d, got %0d",
                      want.start_index, rsp_tdata[cba_pkg::STATUS_W +: cba_pkg::START_W]);
               error_count++;
            end
         end
      end
   end

   task automatic test_size_rounding();
      send_alloc(0);        // zero size
      send_alloc(8191);     // more than the pool
      send_alloc(1);
      send_alloc(16);
      send_alloc(17);       // two buffers
      send_free(0);
      send_free(1);
      send_free(2);         // walks both buffers
      send_free(3);         // already free
      wait_idle();
   endtask

   task automatic test_pool_edge();
      send_alloc(4096);     // whole pool
      send_alloc(1);        // no room
      send_free(255);
      send_alloc(16);       // lands on the last buffer
      send_free(0);         // walk follows the chain into the last buffer
      send_alloc(4096);
      send_free(128);       // mid-run free
      send_alloc(4096);
      send_free(0);
      wait_idle();
   endtask

   task automatic test_free_walk();
      send_alloc(32);
      send_alloc(48);
      send_free(1);         // tail of the first run only
      send_alloc(16);       // refills buffer 1 as its own run
      send_free(0);         // chain bit on 0 pulls buffer 1 along
      send_free(2);
      send_free(255);
      send_free(2);
      wait_idle();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
      int pick;
      int roll;
      sender_idle_pct = idle_pct;
      recv_stall_pct  = stall_pct;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 75) begin
            // well-formed traffic, biased toward freeing when the pool is crowded
            pick = pick_run_start();
            if (pick >= 0 && $urandom_range(99) < (buffers_in_use() > 192 ? 70 : 40))
               send_free(pick);
            else if ($urandom_range(9) == 0)
               send_alloc($urandom_range(257, 4096));
            else
               send_alloc($urandom_range(1, 256));
         end else if (roll < 83) begin
            pick = pick_used_buffer();
            send_free(pick >= 0 ? pick : $urandom_range(255));
         end else if (roll < 91) begin
            send_free($urandom_range(255));
         end else if (roll < 94) begin
            send_alloc(0);
         end else begin
            send_alloc($urandom_range(8191));
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d words outstanding",
               CYCLE_LIMIT, pending_results.size());
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_size_rounding();
      test_pool_edge();
      test_free_walk();
      test_random_traffic(0,  0,  ITEMS_PER_PHASE);
      test_random_traffic(52, 0,  ITEMS_PER_PHASE);
      test_random_traffic(0,  52, ITEMS_PER_PHASE);
      test_random_traffic(37, 37, ITEMS_PER_PHASE);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d result words never arrived", pending_results.size());
         error_count++;
      end
      $display("allocate: %0d granted, %0d refused; free: %0d released, %0d on free buffers",
               alloc_ok, alloc_refused, free_ok, free_missed);
      $display("mismatches: %0d", error_count);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
